// ----- hw/rtl/fdtd_pkg.sv -----
// ----------------------------------------------------------------------------
// fdtd_pkg: shared types and constants for the 1-D field update unit
// Grid size, fixed-point helpers, payload structs and controller commands.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  localparam int GRID_CELLS = 64;
  localparam int CELL_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int FRAC_BITS  = 22;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [5:0]        load_cell;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] source_sample;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         out_cell;
    logic signed [31:0] ex_value;
    logic signed [31:0] hy_value;
    logic               last_cell;
  } out_word_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,
    OP_SRC  = 3'd2,
    OP_HUPD = 3'd3,
    OP_EUPD = 3'd4,
    OP_EMIT = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] idx;
    logic [1:0]        phase;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    else                            return v[31:0];
  endfunction

  // round-half-up product scaling, saturated
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic signed [64:0] r;
    logic signed [42:0] s;
    begin
      r = {p[63], p} + 65'sd2097152;
      s = r[64:22];
      if (s > 43'sh7FFF_FFFF)       qscale = 32'sh7FFF_FFFF;
      else if (s < -43'sh8000_0000) qscale = 32'sh8000_0000;
      else                          qscale = s[31:0];
    end
  endfunction

endpackage

// ----- hw/rtl/fdtd_1d_field_update_unit.sv -----
// ----------------------------------------------------------------------------
// fdtd_1d_field_update_unit: 1-D Yee grid field update with per-cell loss
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_word (fdtd_pkg::in_word_t)
//   out     | output    | out_valid/out_stall | out_word (fdtd_pkg::out_word_t)
//   cfg     | input     | cfg_we              | cfg_data (source_position)
//
// A load or step word is accepted only while idle. A step word runs the source
// update, then an H update of cells 0..N-2 and an E update of cells 1..N-2 on
// the one shared multiplier, then emits one word per cell; out_stall on an
// emit holds the sweep.
// Reset is synchronous; field memories read zero after reset.
// in_stall is high while a word is in progress; out_stall holds the sweep.
// ----------------------------------------------------------------------------
module fdtd_1d_field_update_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdtd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output fdtd_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_data
);

  logic               idle, in_fire;
  logic [5:0]         source_position;
  fdtd_pkg::dp_cmd_t  cmd;
  fdtd_pkg::dp_stat_t stat;

  assign in_stall = !idle;
  assign in_fire  = in_valid && idle;

  always_ff @(posedge clk) begin
    if (rst) source_position <= '0;
    else if (cfg_we) source_position <= cfg_data;
  end

  fdtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .req_step (in_word.req_type == fdtd_pkg::REQ_STEP),
    .load_ok  ({26'd0, in_word.load_cell} < 32'(fdtd_pkg::GRID_CELLS)),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  fdtd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .in_word         (in_word),
    .source_position (source_position),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !idle |-> in_stall) else $error("word accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("output word changed under stall");
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_word.req_type == fdtd_pkg::REQ_LOAD && !out_valid) |=> !out_valid)
    else $error("load produced output");
`endif

endmodule

// ----- hw/rtl/fdtd_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdtd_ctrl: step sequencer
// Walks load, source, H sweep, E sweep and emit sweep, four phases per cell in the H and E sweeps.
// ----------------------------------------------------------------------------
module fdtd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 req_step,
  input  logic                 load_ok,
  input  fdtd_pkg::dp_stat_t   stat,
  output logic                 idle,
  output fdtd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_SRC  = 6'b000100,
    S_HUPD = 6'b001000,
    S_EUPD = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  localparam logic [fdtd_pkg::CELL_W-1:0] LAST =
    fdtd_pkg::CELL_W'(fdtd_pkg::GRID_CELLS - 1);
  localparam logic [fdtd_pkg::CELL_W-1:0] H_END =
    fdtd_pkg::CELL_W'(fdtd_pkg::GRID_CELLS - 2);

  state_t                      state, state_next;
  logic [fdtd_pkg::CELL_W-1:0] idx, idx_next;
  logic [1:0]                  phase, phase_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    phase_next = phase;
    cmd        = '0;
    cmd.op     = fdtd_pkg::OP_NONE;
    cmd.idx    = idx;
    cmd.phase  = phase;
    cmd.last   = (idx == LAST);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req_step) state_next = S_SRC;
          else if (load_ok) state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op = fdtd_pkg::OP_LOAD;
        state_next = S_IDLE;
      end
      S_SRC: begin
        cmd.op = fdtd_pkg::OP_SRC;
        phase_next = phase + 2'd1;
        if (phase == 2'd2) begin
          phase_next = '0;
          idx_next   = '0;
          state_next = S_HUPD;
        end
      end
      S_HUPD: begin
        cmd.op = fdtd_pkg::OP_HUPD;
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          if (idx == H_END) begin
            idx_next   = fdtd_pkg::CELL_W'(1);
            state_next = S_EUPD;
          end else idx_next = idx + 1'b1;
        end
      end
      S_EUPD: begin
        cmd.op = fdtd_pkg::OP_EUPD;
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          if (idx == H_END) begin
            idx_next   = '0;
            state_next = S_EMIT;
          end else idx_next = idx + 1'b1;
        end
      end
      S_EMIT: begin
        // phase 0 reads memories, phase 1 loads the output register once it is not held by out_stall
        if (phase == 2'd0) begin
          cmd.op = fdtd_pkg::OP_EMIT;
          phase_next = 2'd1;
        end else if (!stat.out_busy) begin
          cmd.op = fdtd_pkg::OP_EMIT;
          phase_next = 2'd0;
          if (idx == LAST) state_next = S_IDLE;
          else idx_next = idx + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      phase <= phase_next;
    end
  end

endmodule

// ----- hw/rtl/fdtd_dp.sv -----
// ----------------------------------------------------------------------------
// fdtd_dp: field and coefficient memories with one shared multiplier
// Each cell update takes four phases: read, two products, writeback.
// ----------------------------------------------------------------------------
module fdtd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  fdtd_pkg::in_word_t   in_word,
  input  logic [5:0]           source_position,
  input  fdtd_pkg::dp_cmd_t    cmd,
  output fdtd_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fdtd_pkg::out_word_t  out_word
);

  localparam int N = fdtd_pkg::GRID_CELLS;
  localparam int CW = fdtd_pkg::CELL_W;

  logic signed [31:0] ex_mem [N];
  logic signed [31:0] hy_mem [N];
  logic signed [31:0] ka_mem [N];
  logic signed [31:0] kb_mem [N];
  logic signed [31:0] kc_mem [N];
  logic signed [31:0] kd_mem [N];

  // field values reset to zero: per-entry valid bits
  logic [N-1:0] ex_ok, hy_ok;

  fdtd_pkg::in_word_t  item;
  logic [CW-1:0]       ld_cell;
  logic [CW-1:0]       src_cell;
  logic                src_ok;

  logic signed [31:0] e0, e1, h0, hp, ka, kb, kc, kd;
  logic signed [31:0] p0, curl;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;

  assign ld_cell  = item.load_cell[CW-1:0];
  assign src_cell = source_position[CW-1:0];
  assign src_ok   = ({26'd0, source_position} < 32'(N));

  // one 32x32 multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == fdtd_pkg::OP_HUPD) begin
      mul_a = (cmd.phase == 2'd1) ? ka : kb;
      mul_b = (cmd.phase == 2'd1) ? h0 : curl;
    end else begin
      mul_a = (cmd.phase == 2'd1) ? kc : kd;
      mul_b = (cmd.phase == 2'd1) ? e0 : curl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (in_fire) item <= in_word;
    case (cmd.op)
      fdtd_pkg::OP_LOAD: begin
        ka_mem[ld_cell] <= item.coef_a;
        kb_mem[ld_cell] <= item.coef_b;
        kc_mem[ld_cell] <= item.coef_c;
        kd_mem[ld_cell] <= item.coef_d;
        ex_mem[ld_cell] <= '0;
        hy_mem[ld_cell] <= '0;
      end
      fdtd_pkg::OP_SRC: begin
        if (cmd.phase == 2'd0) e0 <= ex_ok[src_cell] ? ex_mem[src_cell] : '0;
        if (cmd.phase == 2'd1 && src_ok)
          ex_mem[src_cell] <= fdtd_pkg::sat32(34'(e0) + 34'(item.source_sample));
      end
      fdtd_pkg::OP_HUPD: begin
        if (cmd.phase == 2'd0) begin
          e0 <= ex_ok[cmd.idx] ? ex_mem[cmd.idx] : '0;
          e1 <= ex_ok[cmd.idx + 1'b1] ? ex_mem[cmd.idx + 1'b1] : '0;
          h0 <= hy_ok[cmd.idx] ? hy_mem[cmd.idx] : '0;
          ka <= ka_mem[cmd.idx];
          kb <= kb_mem[cmd.idx];
        end
        if (cmd.phase == 2'd1) curl <= fdtd_pkg::sat32(34'(e1) - 34'(e0));
        if (cmd.phase == 2'd2) p0 <= fdtd_pkg::qscale(prod);
        if (cmd.phase == 2'd3)
          hy_mem[cmd.idx] <= fdtd_pkg::sat32(34'(p0) - 34'(fdtd_pkg::qscale(prod)));
      end
      fdtd_pkg::OP_EUPD: begin
        if (cmd.phase == 2'd0) begin
          e0 <= ex_ok[cmd.idx] ? ex_mem[cmd.idx] : '0;
          h0 <= hy_ok[cmd.idx] ? hy_mem[cmd.idx] : '0;
          hp <= hy_ok[cmd.idx - 1'b1] ? hy_mem[cmd.idx - 1'b1] : '0;
          kc <= kc_mem[cmd.idx];
          kd <= kd_mem[cmd.idx];
        end
        if (cmd.phase == 2'd1) curl <= fdtd_pkg::sat32(34'(h0) - 34'(hp));
        if (cmd.phase == 2'd2) p0 <= fdtd_pkg::qscale(prod);
        if (cmd.phase == 2'd3)
          ex_mem[cmd.idx] <= fdtd_pkg::sat32(34'(p0) - 34'(fdtd_pkg::qscale(prod)));
      end
      fdtd_pkg::OP_EMIT: begin
        if (cmd.phase == 2'd0) begin
          e0 <= ex_ok[cmd.idx] ? ex_mem[cmd.idx] : '0;
          h0 <= hy_ok[cmd.idx] ? hy_mem[cmd.idx] : '0;
        end else begin
          out_word.out_cell  <= 6'(cmd.idx);
          out_word.ex_value  <= e0;
          out_word.hy_value  <= h0;
          out_word.last_cell <= cmd.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_ok     <= '0;
      hy_ok     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == fdtd_pkg::OP_LOAD) begin
        ex_ok[ld_cell] <= 1'b1;
        hy_ok[ld_cell] <= 1'b1;
      end
      if (cmd.op == fdtd_pkg::OP_SRC && cmd.phase == 2'd1 && src_ok)
        ex_ok[src_cell] <= 1'b1;
      if (cmd.op == fdtd_pkg::OP_HUPD && cmd.phase == 2'd3) hy_ok[cmd.idx] <= 1'b1;
      if (cmd.op == fdtd_pkg::OP_EUPD && cmd.phase == 2'd3) ex_ok[cmd.idx] <= 1'b1;
      if (cmd.op == fdtd_pkg::OP_EMIT && cmd.phase == 2'd1) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && out_stall;

endmodule
